[hdl/dobd_pkg.sv]
`timescale 1ns / 1ps
// Shared package for the drop-oldest byte deque.
// Holds the store geometry, operation codes and the command and result word types.
// Depends on nothing.
package dobd_pkg;

    // Number of bytes the deque can hold.
    localparam int unsigned DEPTH = 4096;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned FILL_W = $clog2(DEPTH + 1);
    localparam int unsigned CNT_W = 32;

    // DEPTH at the width of the wrap sums, and the fill level of a full store.
    localparam logic [FILL_W:0] DEPTH_SUM = (FILL_W + 1)'(DEPTH);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);
    localparam logic [FILL_W-1:0] FILL_ALMOST = FILL_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_REQUEUE = 2'd1;
    localparam logic [1:0] FUNC_POP = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_in;
        logic       chunk_start;
    } cmd_t;

    typedef struct packed {
        logic [7:0]        data_out;
        logic              data_valid;
        logic [FILL_W-1:0] fill_level;
        logic [CNT_W-1:0]  overflow_lost;
        logic [CNT_W-1:0]  requeue_lost;
        logic [CNT_W-1:0]  short_write_count;
    } result_t;

    // Saturating increment of a 32-bit loss counter.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

    // Next index around the ring.
    function automatic logic [ADDR_W-1:0] idx_inc(input logic [ADDR_W-1:0] v);
        return (v == ADDR_LAST) ? '0 : v + ADDR_W'(1);
    endfunction

    // Previous index around the ring.
    function automatic logic [ADDR_W-1:0] idx_dec(input logic [ADDR_W-1:0] v);
        return (v == '0) ? ADDR_LAST : v - ADDR_W'(1);
    endfunction

endpackage

[hdl/dobd_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module dobd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/drop_oldest_byte_deque.sv]
`timescale 1ns / 1ps
// Drop-oldest byte deque: push at tail, requeue at front, pop oldest, with loss counters.
// Depends on dobd_pkg and on dobd_ram for the byte store.
// The result word is registered: it appears in the cycle after the command for push, requeue
// and an empty pop; for a pop that returns a byte it follows the store read and the read wait state.
// Throughput: one command per cycle, except a pop with data, which holds busy in the read
// wait state while the byte store's registered read port returns the byte.
// Reset clears the pointers, fill level and counters at once; the store needs no clearing.
module drop_oldest_byte_deque (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dobd_pkg::cmd_t   cmd,
    output logic             result_strobe,
    output dobd_pkg::result_t result
);

    // Controller states: idle, or waiting for the store to return a popped byte.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic state_reg;
    logic state_next;

    // Ring pointers and occupancy. The tail is derived as front plus occupancy.
    logic [dobd_pkg::ADDR_W-1:0] front_reg;
    logic [dobd_pkg::ADDR_W-1:0] front_next;
    logic [dobd_pkg::FILL_W-1:0] occ_reg;
    logic [dobd_pkg::FILL_W-1:0] occ_next;

    // Saturating loss counters.
    logic [dobd_pkg::CNT_W-1:0] ovf_reg;
    logic [dobd_pkg::CNT_W-1:0] ovf_next;
    logic [dobd_pkg::CNT_W-1:0] req_reg;
    logic [dobd_pkg::CNT_W-1:0] req_next;
    logic [dobd_pkg::CNT_W-1:0] short_reg;
    logic [dobd_pkg::CNT_W-1:0] short_next;

    // Result word and its strobe.
    dobd_pkg::result_t result_reg;
    dobd_pkg::result_t result_next;
    logic              strobe_reg;

    // Byte store ports.
    logic                        wr_en;
    logic [dobd_pkg::ADDR_W-1:0] wr_addr;
    logic                        rd_en;
    logic [7:0]                  rd_data;

    logic                        accept;
    logic                        full;
    logic                        pop_hit;
    logic [dobd_pkg::ADDR_W-1:0] push_front;
    logic [dobd_pkg::FILL_W-1:0] push_occ;
    logic [dobd_pkg::FILL_W:0]   tail_sum;

    assign accept  = start && !busy;
    assign busy    = (state_reg == ST_READ);
    assign full    = (occ_reg == dobd_pkg::FILL_FULL);
    assign pop_hit = (cmd.func == dobd_pkg::FUNC_POP) && (occ_reg != '0);

    // A push into a full store first drops the oldest byte, so the tail is computed from
    // the advanced front and one less byte. The wrap is a single compare and subtract
    // because front plus occupancy stays below twice the depth.
    assign push_front = full ? dobd_pkg::idx_inc(front_reg) : front_reg;
    assign push_occ   = full ? dobd_pkg::FILL_ALMOST : occ_reg;
    assign tail_sum   = (dobd_pkg::FILL_W + 1)'(push_front) + (dobd_pkg::FILL_W + 1)'(push_occ);

    always_comb
    begin
        front_next = front_reg;
        occ_next   = occ_reg;
        ovf_next   = ovf_reg;
        req_next   = req_reg;
        short_next = short_reg;
        wr_en      = 1'b0;
        wr_addr    = push_front;

        case (cmd.func)
            dobd_pkg::FUNC_PUSH:
            begin
                if (full)
                begin
                    ovf_next = dobd_pkg::sat_inc(ovf_reg);
                end
                front_next = push_front;
                occ_next   = push_occ + dobd_pkg::FILL_W'(1);
                wr_en      = accept;
                if (tail_sum >= dobd_pkg::DEPTH_SUM)
                begin
                    wr_addr = dobd_pkg::ADDR_W'(tail_sum - dobd_pkg::DEPTH_SUM);
                end
                else
                begin
                    wr_addr = dobd_pkg::ADDR_W'(tail_sum);
                end
            end
            dobd_pkg::FUNC_REQUEUE:
            begin
                if (cmd.chunk_start)
                begin
                    short_next = dobd_pkg::sat_inc(short_reg);
                end
                if (full)
                begin
                    req_next = dobd_pkg::sat_inc(req_reg);
                end
                else
                begin
                    front_next = dobd_pkg::idx_dec(front_reg);
                    occ_next   = occ_reg + dobd_pkg::FILL_W'(1);
                    wr_en      = accept;
                    wr_addr    = dobd_pkg::idx_dec(front_reg);
                end
            end
            dobd_pkg::FUNC_POP:
            begin
                if (pop_hit)
                begin
                    front_next = dobd_pkg::idx_inc(front_reg);
                    occ_next   = occ_reg - dobd_pkg::FILL_W'(1);
                end
            end
            default:
            begin
                // The unused code leaves everything as it is.
            end
        endcase
    end

    // The read is issued at the accepting edge; the byte arrives in the next cycle.
    assign rd_en = accept && pop_hit;

    always_comb
    begin
        result_next                   = result_reg;
        if (accept)
        begin
            result_next.data_out          = '0;
            result_next.data_valid        = pop_hit;
            result_next.fill_level        = occ_next;
            result_next.overflow_lost     = ovf_next;
            result_next.requeue_lost      = req_next;
            result_next.short_write_count = short_next;
        end
        else if (state_reg == ST_READ)
        begin
            result_next.data_out = rd_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && pop_hit)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            front_reg  <= '0;
            occ_reg    <= '0;
            ovf_reg    <= '0;
            req_reg    <= '0;
            short_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                front_reg <= front_next;
                occ_reg   <= occ_next;
                ovf_reg   <= ovf_next;
                req_reg   <= req_next;
                short_reg <= short_next;
            end
            // A pop with data shows its word only once the byte is back from the store.
            strobe_reg <= (accept && !pop_hit) || (state_reg == ST_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Only one command is in flight, so a write and a read of the same entry never
    // overlap and the store needs no forwarding.
    dobd_ram #(
        .WIDTH (8),
        .DEPTH (dobd_pkg::DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.data_in),
        .rd_en   (rd_en),
        .rd_addr (front_reg),
        .rd_data (rd_data)
    );

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // The fill level never passes the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= dobd_pkg::FILL_FULL)
        else $error("occupancy above depth");

    // The read wait state is entered only after accepting a pop with data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> $past(accept && pop_hit))
        else $error("read wait without a pop");

    // The read wait state always ends with a result word carrying a valid byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (result_strobe && result.data_valid))
        else $error("popped byte not delivered");

    // The overflow counter never goes backward.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (ovf_reg >= $past(ovf_reg)))
        else $error("overflow counter decreased");

endmodule
